@@ rtl/rpn_pkg.sv @@
// Shared constants, codes and types of the postfix expression evaluator.
package rpn_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);

    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;
    localparam int CNT_W  = $clog2(DATA_W + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QP_W        = $clog2(QUEUE_DEPTH);
    localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] FN_PUSH = 3'd0;
    localparam logic [2:0] FN_ADD  = 3'd1;
    localparam logic [2:0] FN_SUB  = 3'd2;
    localparam logic [2:0] FN_MUL  = 3'd3;
    localparam logic [2:0] FN_DIV  = 3'd4;
    localparam logic [2:0] FN_END  = 3'd5;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_MISSING  = 3'd1;
    localparam logic [2:0] ST_DIVZERO  = 3'd2;
    localparam logic [2:0] ST_OVERFLOW = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;
    localparam logic [2:0] ST_TOOMANY  = 3'd5;

    typedef struct packed {
        logic [2:0]        op;
        logic [DATA_W-1:0] value;
    } t_tok;

endpackage

@@ rtl/rpn_stack_evaluator_unit.sv @@
// Top level of the postfix expression evaluator on a Q16.16 operand stack.
// Push, end and discarded tokens execute in the idle state; add and subtract pass through
// the calculate state, multiply also through the multiply state, and divide waits in the
// divide state for the restoring divider, which resolves one quotient bit per cycle and
// skips the bit loop when the quotient overflows 32 bits. Tokens are held in a two-entry
// queue before execution; an end token's result appears in the cycle after it executes.
// Synchronous active-low reset empties the queue and stack, clears the error and output.
module rpn_stack_evaluator_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [2:0]                 i_func,
    input  logic [rpn_pkg::DATA_W-1:0] i_value,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [rpn_pkg::DATA_W-1:0] o_result,
    output logic [2:0]                 o_status
);
    import rpn_pkg::*;

    logic tok_valid;
    t_tok tok;
    logic tok_pop;

    rpn_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_func      (i_func),
        .i_value     (i_value),
        .o_tok_valid (tok_valid),
        .o_tok       (tok),
        .i_tok_pop   (tok_pop)
    );

    rpn_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (tok_valid),
        .i_tok       (tok),
        .o_tok_pop   (tok_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_result    (o_result),
        .o_status    (o_status)
    );

endmodule

@@ rtl/rpn_front.sv @@
// Token intake: accepts tokens, drops unknown codes and queues the rest.
module rpn_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [2:0]                i_func,
    input  logic [rpn_pkg::DATA_W-1:0] i_value,
    output logic                      o_tok_valid,
    output rpn_pkg::t_tok             o_tok,
    input  logic                      i_tok_pop
);
    import rpn_pkg::*;

    t_tok            r_q [QUEUE_DEPTH];
    logic [QP_W-1:0] r_wp, n_wp;
    logic [QP_W-1:0] r_rp, n_rp;
    logic [QC_W-1:0] r_cnt, n_cnt;
    logic            full;
    logic            push;
    logic            pop;
    t_tok            tok_in;

    assign full        = (r_cnt == QC_W'(QUEUE_DEPTH));
    assign o_stall     = full;
    assign push        = i_valid && !full && (i_func <= FN_END);
    assign o_tok_valid = (r_cnt != '0);
    assign pop         = i_tok_pop && o_tok_valid;
    assign o_tok       = r_q[r_rp];

    always_comb begin
        tok_in.op    = i_func;
        tok_in.value = i_value;
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (push) begin
            n_wp = (r_wp == QP_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + QP_W'(1);
        end
        if (pop) begin
            n_rp = (r_rp == QP_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + QP_W'(1);
        end
        if (push && !pop) begin
            n_cnt = r_cnt + QC_W'(1);
        end else if (pop && !push) begin
            n_cnt = r_cnt - QC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= tok_in;
        end
    end

endmodule

@@ rtl/rpn_div.sv @@
// Radix-2 restoring divider for Q16.16 magnitudes, one quotient bit per cycle.
module rpn_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rpn_pkg::DATA_W-1:0] i_num,
    input  logic [rpn_pkg::DATA_W-1:0] i_den,
    output logic                       o_done,
    output logic                       o_ovf,
    output logic [rpn_pkg::DATA_W-1:0] o_quot
);
    import rpn_pkg::*;

    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic                r_ovf, n_ovf;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [DATA_W-1:0]   r_rem, n_rem;
    logic [DATA_W-1:0]   r_shift, n_shift;
    logic [DATA_W-1:0]   r_den, n_den;
    logic [DATA_W:0]     trial;
    logic                ge;
    logic                start_ovf;

    assign trial     = {r_rem, r_shift[DATA_W-1]};
    assign ge        = (trial >= {1'b0, r_den});
    assign start_ovf = ({{FRAC_W{1'b0}}, i_num} >= {i_den, {FRAC_W{1'b0}}});

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_ovf   = r_ovf;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_shift = r_shift;
        n_den   = r_den;
        if (i_start) begin
            n_den = i_den;
            n_ovf = start_ovf;
            if (start_ovf) begin
                n_done = 1'b1;
                n_busy = 1'b0;
            end else begin
                n_busy  = 1'b1;
                n_cnt   = CNT_W'(DATA_W);
                n_rem   = {{(DATA_W - FRAC_W){1'b0}}, i_num[DATA_W-1:FRAC_W]};
                n_shift = {i_num[FRAC_W-1:0], {(DATA_W - FRAC_W){1'b0}}};
            end
        end else if (r_busy) begin
            n_rem   = ge ? DATA_W'(trial - {1'b0, r_den}) : trial[DATA_W-1:0];
            n_shift = {r_shift[DATA_W-2:0], ge};
            n_cnt   = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ovf   <= n_ovf;
        r_rem   <= n_rem;
        r_shift <= n_shift;
        r_den   <= n_den;
    end

    assign o_done = r_done;
    assign o_ovf  = r_ovf;
    assign o_quot = r_shift;

endmodule

@@ rtl/rpn_back.sv @@
// Execution side: operand stack, arithmetic sequencer and result register.
module rpn_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_tok_valid,
    input  rpn_pkg::t_tok              i_tok,
    output logic                       o_tok_pop,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [rpn_pkg::DATA_W-1:0] o_result,
    output logic [2:0]                 o_status
);
    import rpn_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CALC = 2'd1;
    localparam logic [1:0] S_MUL  = 2'd2;
    localparam logic [1:0] S_DIV  = 2'd3;

    logic [DATA_W-1:0]   r_mem [STACK_DEPTH];
    logic [1:0]          r_state, n_state;
    logic [SP_W-1:0]     r_sp, n_sp;
    logic [2:0]          r_err, n_err;
    logic [2:0]          r_op, n_op;
    logic [DATA_W-1:0]   r_tos, n_tos;
    logic                r_neg, n_neg;
    logic [2*DATA_W-1:0] r_prod, n_prod;
    logic [DATA_W-1:0]   r_rd;
    logic                r_out_valid, n_out_valid;
    logic [DATA_W-1:0]   r_result, n_result;
    logic [2:0]          r_status, n_status;
    logic [SP_W-1:0]     sp_m1;
    logic [SP_W-1:0]     sp_m2;
    logic                mem_we;
    logic                out_free;
    logic [DATA_W:0]     sum;
    logic [DATA_W:0]     diff;
    logic [DATA_W-1:0]   mag_a;
    logic [DATA_W-1:0]   mag_b;
    logic                div_start;
    logic                div_done;
    logic                div_ovf;
    logic [DATA_W-1:0]   div_quot;

    function automatic logic [DATA_W-1:0] sat_mag(input logic [DATA_W+FRAC_W-1:0] mag,
                                                  input logic neg);
        logic [DATA_W+FRAC_W-1:0] lim;
        logic [DATA_W-1:0]        res;
        lim = {{FRAC_W{1'b0}}, 1'b1, {(DATA_W - 1){1'b0}}};
        if (neg) begin
            res = (mag > lim) ? {1'b1, {(DATA_W - 1){1'b0}}} : DATA_W'(-mag[DATA_W-1:0]);
        end else begin
            res = (mag >= lim) ? {1'b0, {(DATA_W - 1){1'b1}}} : mag[DATA_W-1:0];
        end
        return res;
    endfunction

    function automatic logic [DATA_W-1:0] sat_sum(input logic [DATA_W:0] s);
        logic [DATA_W-1:0] res;
        if (s[DATA_W] != s[DATA_W-1]) begin
            res = s[DATA_W] ? {1'b1, {(DATA_W - 1){1'b0}}} : {1'b0, {(DATA_W - 1){1'b1}}};
        end else begin
            res = s[DATA_W-1:0];
        end
        return res;
    endfunction

    assign sp_m1    = r_sp - SP_W'(1);
    assign sp_m2    = r_sp - SP_W'(2);
    assign out_free = !r_out_valid || !i_stall;
    assign sum      = {r_rd[DATA_W-1], r_rd} + {r_tos[DATA_W-1], r_tos};
    assign diff     = {r_rd[DATA_W-1], r_rd} - {r_tos[DATA_W-1], r_tos};
    assign mag_a    = r_rd[DATA_W-1] ? DATA_W'(-r_rd) : r_rd;
    assign mag_b    = r_tos[DATA_W-1] ? DATA_W'(-r_tos) : r_tos;

    rpn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (mag_a),
        .i_den   (mag_b),
        .o_done  (div_done),
        .o_ovf   (div_ovf),
        .o_quot  (div_quot)
    );

    always_comb begin
        n_state     = r_state;
        n_sp        = r_sp;
        n_err       = r_err;
        n_op        = r_op;
        n_tos       = r_tos;
        n_neg       = r_neg;
        n_prod      = r_prod;
        n_out_valid = r_out_valid && i_stall;
        n_result    = r_result;
        n_status    = r_status;
        o_tok_pop   = 1'b0;
        mem_we      = 1'b0;
        div_start   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_tok_valid) begin
                    if (i_tok.op == FN_END) begin
                        if (out_free) begin
                            o_tok_pop   = 1'b1;
                            n_out_valid = 1'b1;
                            n_result    = '0;
                            if (r_err != ST_OK) begin
                                n_status = r_err;
                            end else if (r_sp == '0) begin
                                n_status = ST_EMPTY;
                            end else if (r_sp != SP_W'(1)) begin
                                n_status = ST_TOOMANY;
                            end else begin
                                n_status = ST_OK;
                                n_result = r_tos;
                            end
                            n_sp  = '0;
                            n_err = ST_OK;
                        end
                    end else if (r_err != ST_OK) begin
                        o_tok_pop = 1'b1;
                    end else if (i_tok.op == FN_PUSH) begin
                        o_tok_pop = 1'b1;
                        if (r_sp == SP_W'(STACK_DEPTH)) begin
                            n_err = ST_OVERFLOW;
                        end else begin
                            mem_we = (r_sp != '0);
                            n_tos  = i_tok.value;
                            n_sp   = r_sp + SP_W'(1);
                        end
                    end else begin
                        o_tok_pop = 1'b1;
                        if (r_sp < SP_W'(2)) begin
                            n_err = ST_MISSING;
                        end else if (i_tok.op == FN_DIV && r_tos == '0) begin
                            n_err = ST_DIVZERO;
                        end else begin
                            n_op    = i_tok.op;
                            n_state = S_CALC;
                        end
                    end
                end
            end
            S_CALC: begin
                n_neg = r_rd[DATA_W-1] ^ r_tos[DATA_W-1];
                case (r_op)
                    FN_ADD: begin
                        n_tos   = sat_sum(sum);
                        n_sp    = sp_m1;
                        n_state = S_IDLE;
                    end
                    FN_SUB: begin
                        n_tos   = sat_sum(diff);
                        n_sp    = sp_m1;
                        n_state = S_IDLE;
                    end
                    FN_MUL: begin
                        n_prod  = (2*DATA_W)'(mag_a) * (2*DATA_W)'(mag_b);
                        n_state = S_MUL;
                    end
                    default: begin
                        div_start = 1'b1;
                        n_state   = S_DIV;
                    end
                endcase
            end
            S_MUL: begin
                n_tos   = sat_mag(r_prod[2*DATA_W-1:FRAC_W], r_neg);
                n_sp    = sp_m1;
                n_state = S_IDLE;
            end
            S_DIV: begin
                if (div_done) begin
                    n_tos   = sat_mag(div_ovf ? {(DATA_W + FRAC_W){1'b1}}
                                              : {{FRAC_W{1'b0}}, div_quot}, r_neg);
                    n_sp    = sp_m1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sp        <= '0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sp        <= n_sp;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_tos    <= n_tos;
        r_neg    <= n_neg;
        r_prod   <= n_prod;
        r_result <= n_result;
        r_status <= n_status;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[sp_m1[ADDR_W-1:0]] <= r_tos;
        end
        r_rd <= r_mem[sp_m2[ADDR_W-1:0]];
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;
    assign o_status = r_status;

    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SP_W'(STACK_DEPTH))
        else $error("Stack pointer beyond the stack depth.");

    a_err_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ST_OK) |-> (r_result == '0))
        else $error("Error status reported with a nonzero result.");

    a_busy_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_err == ST_OK && r_sp >= SP_W'(2)))
        else $error("Arithmetic in progress with an error or too few operands.");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("Divider finished outside the divide state.");

endmodule

@@ tb/sv/rpn_stack_evaluator_unit_tb.sv @@
// Self-checking testbench of the postfix expression evaluator with a built-in token predictor.
`timescale 1ns / 100ps

module rpn_stack_evaluator_unit_tb;
    import rpn_pkg::*;

    localparam logic [2:0] FN_UNUSED6 = 3'd6;
    localparam logic [2:0] FN_UNUSED7 = 3'd7;

    localparam int     RANDOM_ITEMS = 1050;
    localparam int     PHASE_LEN    = 96;
    localparam int     TAIL_CYCLES  = 64;
    localparam int     CYCLE_LIMIT  = 400000;
    localparam longint Q_MAX        = 64'sh0000_0000_7FFF_FFFF;
    localparam longint Q_MIN        = -64'sh0000_0000_8000_0000;

    typedef struct packed {
        logic [2:0]        func;
        logic [DATA_W-1:0] value;
        logic              typed;
        logic [DATA_W-1:0] exp_result;
        logic [2:0]        exp_status;
    } t_token_row;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic [2:0]        status;
    } t_eval_out;

    localparam int N_DIRECTED = 25;
    localparam t_token_row DIRECTED_ROWS [N_DIRECTED] = '{
        '{FN_END,     32'h0000_0000, 1'b1, 32'h0000_0000, ST_EMPTY},
        '{FN_PUSH,    32'h7FFF_FFFF, 1'b0, 32'h0000_0000, ST_OK},
        '{FN_PUSH,    32'h0000_0001, 1'b0, 32'h0000_0000, ST_OK},
        '{FN_ADD,     32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
        '{FN_END,     32'hFFFF_FFFF, 1'b1, 32'h7FFF_FFFF, ST_OK},
        '{FN_PUSH,    32'h8000_0000, 1'b0, 32'h0000_0000, ST_OK},
        '{FN_PUSH,    32'h0000_0001, 1'b0, 32'h0000_0000, ST_OK},
        '{FN_SUB,     32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
        '{FN_END,     32'h0000_0000, 1'b1, 32'h8000_0000, ST_OK},
        '{FN_PUSH,    32'h0001_0000, 1'b0, 32'h0000_0000, ST_OK},
        '{FN_PUSH,    32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
        '{FN_DIV,     32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
        '{FN_PUSH,    32'h0005_0000, 1'b0, 32'h0000_0000, ST_OK},
        '{FN_END,     32'h0000_0000, 1'b1, 32'h0000_0000, ST_DIVZERO},
        '{FN_ADD,     32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
        '{FN_END,     32'h0000_0000, 1'b1, 32'h0000_0000, ST_MISSING},
        '{FN_PUSH,    32'hFFFF_FFFF, 1'b0, 32'h0000_0000, ST_OK},
        '{FN_PUSH,    32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
        '{FN_UNUSED7, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, ST_OK},
        '{FN_END,     32'h0000_0000, 1'b1, 32'h0000_0000, ST_TOOMANY},
        '{FN_PUSH,    32'h8000_0000, 1'b0, 32'h0000_0000, ST_OK},
        '{FN_PUSH,    32'hFFFF_0000, 1'b0, 32'h0000_0000, ST_OK},
        '{FN_UNUSED6, 32'h1234_5678, 1'b0, 32'h0000_0000, ST_OK},
        '{FN_MUL,     32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
        '{FN_END,     32'h0000_0000, 1'b1, 32'h7FFF_FFFF, ST_OK}
    };

    localparam int SEND_IDLE_PCT  [4] = '{0, 67, 0, 11};
    localparam int RECV_STALL_PCT [4] = '{0, 0, 67, 11};

    logic              i_clk     = 1'b0;
    logic              i_rst_n   = 1'b0;
    logic              i_valid   = 1'b0;
    logic [2:0]        i_func    = FN_PUSH;
    logic [DATA_W-1:0] i_value   = '0;
    logic              i_stall   = 1'b0;
    logic              o_stall;
    logic              o_valid;
    logic [DATA_W-1:0] o_result;
    logic [2:0]        o_status;

    logic              feeding    = 1'b0;
    int                idle_phase = 0;

    t_token_row        stim_q [$];
    t_eval_out         pending_results [$];
    int                tokens_sent  = 0;
    int                results_seen = 0;
    int                fail_count   = 0;
    int                cycle_count  = 0;
    int                status_tally [6] = '{0, 0, 0, 0, 0, 0};

    logic [DATA_W-1:0] eval_stack [STACK_DEPTH];
    int                eval_sp  = 0;
    logic [2:0]        eval_err = ST_OK;

    rpn_stack_evaluator_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_func   (i_func),
        .i_value  (i_value),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result),
        .o_status (o_status)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [DATA_W-1:0] clamp_q16(input longint x);
        if (x > Q_MAX) return 32'h7FFF_FFFF;
        if (x < Q_MIN) return 32'h8000_0000;
        return x[DATA_W-1:0];
    endfunction

    function automatic logic [63:0] mag64(input longint x);
        return (x < 0) ? 64'(-x) : 64'(x);
    endfunction

    function automatic bit eval_token(input logic [2:0] fn, input logic [DATA_W-1:0] val,
                                      output t_eval_out out);
        longint      a;
        longint      b;
        longint      r;
        logic [63:0] mag;
        bit          neg;
        out = '{result: '0, status: ST_OK};
        if (fn == FN_END) begin
            if (eval_err != ST_OK) out.status = eval_err;
            else if (eval_sp == 0) out.status = ST_EMPTY;
            else if (eval_sp > 1) out.status = ST_TOOMANY;
            else out.result = eval_stack[0];
            eval_sp  = 0;
            eval_err = ST_OK;
            return 1'b1;
        end
        if (fn > FN_END || eval_err != ST_OK) return 1'b0;
        if (fn == FN_PUSH) begin
            if (eval_sp >= STACK_DEPTH) begin
                eval_err = ST_OVERFLOW;
            end else begin
                eval_stack[eval_sp] = val;
                eval_sp++;
            end
            return 1'b0;
        end
        if (eval_sp < 2) begin
            eval_err = ST_MISSING;
            return 1'b0;
        end
        a   = longint'($signed(eval_stack[eval_sp-2]));
        b   = longint'($signed(eval_stack[eval_sp-1]));
        neg = (a < 0) != (b < 0);
        case (fn)
            FN_ADD: r = a + b;
            FN_SUB: r = a - b;
            FN_MUL: begin
                mag = (mag64(a) * mag64(b)) >> FRAC_W;
                r   = longint'(mag);
                if (neg) r = -r;
            end
            default: begin
                if (b == 0) begin
                    eval_err = ST_DIVZERO;
                    return 1'b0;
                end
                mag = (mag64(a) << FRAC_W) / mag64(b);
                r   = longint'(mag);
                if (neg) r = -r;
            end
        endcase
        eval_sp--;
        eval_stack[eval_sp-1] = clamp_q16(r);
        return 1'b0;
    endfunction

    function automatic logic [DATA_W-1:0] pick_q16();
        int sel;
        int ip;
        sel = $urandom_range(99);
        if (sel < 35) return $urandom;
        if (sel < 70) begin
            ip = int'($urandom_range(16)) - 8;
            return 32'(ip * 65536 + int'($urandom_range(65535)));
        end
        if (sel < 78) return '0;
        if (sel < 90) begin
            case ($urandom_range(3))
                0: return 32'h7FFF_FFFF;
                1: return 32'h8000_0000;
                2: return 32'h0001_0000;
                default: return 32'hFFFF_0000;
            endcase
        end
        ip = int'($urandom_range(255));
        return ($urandom_range(1) == 1) ? 32'(-ip) : 32'(ip);
    endfunction

    task automatic add_token(input logic [2:0] fn, input logic [DATA_W-1:0] val);
        stim_q.push_back('{func: fn, value: val, typed: 1'b0, exp_result: '0,
                           exp_status: ST_OK});
    endtask

    function automatic logic [2:0] pick_arith();
        return 3'($urandom_range(int'(FN_DIV), int'(FN_ADD)));
    endfunction

    task automatic gen_expr(input int n_operands, input bit noisy);
        int depth;
        int pushed;
        depth  = 0;
        pushed = 0;
        while (pushed < n_operands || depth > 1) begin
            if (noisy && $urandom_range(5) == 0)
                add_token(($urandom_range(1) == 1) ? FN_UNUSED6 : FN_UNUSED7, $urandom);
            if (pushed < n_operands && (depth < 2 || $urandom_range(1) == 0)) begin
                add_token(FN_PUSH, pick_q16());
                pushed++;
                depth++;
            end else begin
                add_token(pick_arith(), $urandom);
                depth--;
            end
        end
        add_token(FN_END, $urandom);
    endtask

    task automatic gen_deep(input int pushes);
        repeat (pushes) add_token(FN_PUSH, pick_q16());
        if (pushes <= STACK_DEPTH) begin
            repeat (pushes - 1) add_token(pick_arith(), $urandom);
        end
        add_token(FN_END, $urandom);
    endtask

    always @(posedge i_clk) begin : token_feed
        t_eval_out  predicted;
        t_token_row row;
        int         phase;
        if (i_valid && !o_stall) begin
            row = stim_q[tokens_sent];
            if (eval_token(i_func, i_value, predicted)) begin
                if (row.typed) pending_results.push_back('{result: row.exp_result,
                                                           status: row.exp_status});
                else pending_results.push_back(predicted);
            end
            tokens_sent++;
        end
        if (feeding && (!i_valid || !o_stall)) begin
            phase       = (tokens_sent / PHASE_LEN) % 4;
            idle_phase <= phase;
            if (tokens_sent < stim_q.size() && $urandom_range(99) >= SEND_IDLE_PCT[phase]) begin
                i_valid <= 1'b1;
                i_func  <= stim_q[tokens_sent].func;
                i_value <= stim_q[tokens_sent].value;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_eval_out want;
        if (o_valid && !i_stall) begin
            results_seen++;
            if (o_status <= ST_TOOMANY) status_tally[o_status]++;
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected: result %h status %0d",
                       o_result, o_status);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_result !== want.result) begin
                    $error("result: expected %h, actual %h", want.result, o_result);
                    fail_count++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_status);
                    fail_count++;
                end
            end
        end
        if (feeding) i_stall <= ($urandom_range(99) < RECV_STALL_PCT[idle_phase]);
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Run stopped at the cycle limit with %0d results outstanding.",
                 pending_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : main_seq
        int  sel;
        int  n;
        bit  deep_done;
        logic [2:0] fn;
        deep_done = 1'b0;
        foreach (DIRECTED_ROWS[k]) stim_q.push_back(DIRECTED_ROWS[k]);
        while (stim_q.size() - N_DIRECTED < RANDOM_ITEMS) begin
            if (!deep_done && stim_q.size() - N_DIRECTED > 300) begin
                gen_deep(STACK_DEPTH);
                gen_deep(STACK_DEPTH + 3);
                deep_done = 1'b1;
            end
            sel = $urandom_range(99);
            if (sel < 70) begin
                gen_expr($urandom_range(6, 1), 1'b0);
            end else if (sel < 82) begin
                gen_expr($urandom_range(6, 1), 1'b1);
            end else begin
                n = $urandom_range(5);
                repeat (n) begin
                    fn = 3'($urandom_range(7));
                    if (fn == FN_END) fn = FN_DIV;
                    add_token(fn, pick_q16());
                end
                add_token(FN_END, $urandom);
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        feeding <= 1'b1;

        while (tokens_sent < stim_q.size() || pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Transferred %0d tokens (%0d directed) and checked %0d results in %0d cycles.",
                 tokens_sent, N_DIRECTED, results_seen, cycle_count);
        $display("Status mix: ok %0d, missing %0d, divide by zero %0d, overflow %0d,",
                 status_tally[0], status_tally[1], status_tally[2], status_tally[3]);
        $display("            empty %0d, too many %0d.", status_tally[4], status_tally[5]);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
